[rtl/m4tu_pkg.sv]
// Shared types and constants for the 4x4 fixed-point matrix unit.
// No dependencies.
package m4tu_pkg;
  typedef enum logic [2:0] {
    OP_LOAD_CUR = 3'd0,
    OP_LOAD_OPD = 3'd1,
    OP_MUL      = 3'd2,
    OP_ADD      = 3'd3,
    OP_TRANS    = 3'd4,
    OP_XLATE    = 3'd5,
    OP_IDENT    = 3'd6,
    OP_READ     = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_XLATE = 2'd2,
    ST_READ = 2'd3
  } state_t;

  typedef logic signed [31:0] word_t;
  typedef word_t row_t [4];

  localparam int unsigned NUM_LANES = 4;

  function automatic word_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction
endpackage

[rtl/matrix4_transform_unit_core.sv]
// 4x4 Q-format matrix unit: top level with matrix stores, sequencer and lanes.
// Depends on m4tu_pkg and m4tu_lane.
//
// Loads, add, transpose and identity finish at the accepting edge, so such
// requests can follow back to back. Multiply keeps in_tready low after its
// request while it walks the rows of the current matrix through four MAC
// lanes, one result row per cycle, and while the product register in each
// lane drains. Translate uses the lanes once and keeps in_tready low until
// its result row is written. A read out sends four result rows (out_tlast
// marks row 3) and keeps in_tready low until its last row is taken; stalls
// on out_tready lengthen that wait.
module matrix4_transform_unit_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [2:0] opcode, [4:3] row_index, [36:5] elem0, [68:37] elem1,
  // [100:69] elem2, [132:101] elem3, zero pad to 136
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] out_row, [33:2] col0, [65:34] col1, [97:66] col2, [129:98] col3, pad
  output logic [135:0] out_tdata,
  output logic         out_tlast
);
  import m4tu_pkg::*;

  word_t cur_r [16];
  word_t opd_r [16];
  word_t cur_nxt [16];
  word_t tmp_r [16];
  state_t state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [2:0] mcnt_r, mcnt_nxt;
  logic pend_r;
  logic [1:0] prow_r;

  op_t op;
  logic [1:0] row;
  word_t e [4];
  logic acc;
  assign op = op_t'(in_tdata[2:0]);
  assign row = in_tdata[4:3];
  assign e[0] = in_tdata[36:5];
  assign e[1] = in_tdata[68:37];
  assign e[2] = in_tdata[100:69];
  assign e[3] = in_tdata[132:101];
  assign acc = in_tvalid && in_tready;

  word_t xe_r [3];
  word_t la [4][4];
  word_t lb [4][4];
  word_t lbias [4];
  logic signed [63:0] lsum [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        if (state_r == ST_MUL) begin
          la[c][k] = cur_r[{cnt_r, 2'(k)}];
          lb[c][k] = opd_r[{2'(k), 2'(c)}];
        end else begin
          la[c][k] = (k < 3) ? cur_r[{2'(k), 2'(c)}] : '0;
          lb[c][k] = (k < 3) ? xe_r[k] : '0;
        end
      end
      lbias[c] = (state_r == ST_MUL) ? '0 : cur_r[{2'd3, 2'(c)}];
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    m4tu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk(clk), .a(la[g]), .b(lb[g]), .bias(lbias[g]), .sum_q(lsum[g]));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    mcnt_nxt = mcnt_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && op == OP_MUL) begin
          state_nxt = ST_MUL; cnt_nxt = '0; mcnt_nxt = '0;
        end else if (acc && op == OP_XLATE) begin
          state_nxt = ST_XLATE; mcnt_nxt = '0;
        end else if (acc && op == OP_READ) begin
          state_nxt = ST_READ; cnt_nxt = '0;
        end
      end
      ST_MUL: begin
        mcnt_nxt = mcnt_r + 3'd1;
        if (cnt_r != 2'd3) cnt_nxt = cnt_r + 2'd1;
        if (mcnt_r == 3'd4) state_nxt = ST_IDLE;
      end
      ST_XLATE: begin
        mcnt_nxt = mcnt_r + 3'd1;
        if (mcnt_r == 3'd1) state_nxt = ST_IDLE;
      end
      ST_READ: begin
        if (!out_tvalid || out_tready) begin
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_r == 2'd3) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Matrix update.
  always_comb begin
    cur_nxt = cur_r;
    if (state_r == ST_IDLE && acc) begin
      case (op)
        OP_LOAD_CUR: for (int c = 0; c < 4; c++) cur_nxt[{row, 2'(c)}] = e[c];
        OP_ADD: for (int k = 0; k < 16; k++)
          cur_nxt[k] = sat32(64'(cur_r[k]) + 64'(opd_r[k]));
        OP_TRANS: for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) cur_nxt[{2'(c), 2'(r)}] = cur_r[{2'(r), 2'(c)}];
        OP_IDENT: for (int k = 0; k < 16; k++)
          cur_nxt[k] = (k % 5 == 0) ? word_t'(1 << FRAC_BITS) : '0;
        default: ;
      endcase
    end else if (state_r == ST_MUL && mcnt_r == 3'd4) begin
      for (int k = 0; k < 12; k++) cur_nxt[k] = tmp_r[k];
      for (int c = 0; c < 4; c++) cur_nxt[12 + c] = sat32(lsum[c]);
    end else if (state_r == ST_XLATE && mcnt_r == 3'd1) begin
      for (int c = 0; c < 4; c++) cur_nxt[12 + c] = sat32(lsum[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      mcnt_r <= '0;
      cur_r <= '{default: '0};
      opd_r <= '{default: '0};
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      mcnt_r <= mcnt_nxt;
      cur_r <= cur_nxt;
      if (state_r == ST_IDLE && acc && op == OP_LOAD_OPD) begin
        for (int c = 0; c < 4; c++) opd_r[{row, 2'(c)}] <= e[c];
      end
      if (state_r == ST_READ && (!out_tvalid || out_tready)) begin
        pend_r <= 1'b1;
      end else if (out_tready) begin
        pend_r <= 1'b0;
      end
    end
  end

  // Payload: lane results, translate operands, output row.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && acc) begin
      xe_r <= '{e[0], e[1], e[2]};
    end
    if (state_r == ST_MUL && mcnt_r != 3'd0) begin
      for (int c = 0; c < 4; c++) tmp_r[{2'(mcnt_r - 3'd1), 2'(c)}] <= sat32(lsum[c]);
    end
    if (state_r == ST_READ && (!out_tvalid || out_tready)) begin
      prow_r <= cnt_r;
      out_tdata <= {6'd0, cur_r[{cnt_r, 2'd3}], cur_r[{cnt_r, 2'd2}],
                    cur_r[{cnt_r, 2'd1}], cur_r[{cnt_r, 2'd0}], cnt_r};
    end
  end

  assign out_tvalid = pend_r;
  assign out_tlast = (prow_r == 2'd3);
  assign in_tready = (state_r == ST_IDLE) && !pend_r;
endmodule

[rtl/m4tu_lane.sv]
// One multiply-accumulate lane: sum of four truncated fixed-point products
// plus a bias term, as a 64-bit sum that the top level saturates to 32 bits. Depends on m4tu_pkg.
module m4tu_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  m4tu_pkg::word_t   a [4],
  input  m4tu_pkg::word_t   b [4],
  input  m4tu_pkg::word_t   bias,
  output logic signed [63:0] sum_q
);
  import m4tu_pkg::*;

  logic signed [63:0] prod_r [4];
  logic signed [63:0] prod_nxt [4];
  word_t bias_r;

  // Register the products, then add.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_nxt[i] = (64'(a[i]) * 64'(b[i])) >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    bias_r <= bias;
  end

  // With at least eight fraction bits the four shifted products and the bias
  // always fit in 64 bits.
  assign sum_q = prod_r[0] + prod_r[1] + prod_r[2] + prod_r[3] + 64'(bias_r);
endmodule

[rtl/m4tu_checker.sv]
// Port-level checks for matrix4_transform_unit_core, bound to the top level.
// Depends only on the top-level ports.
module m4tu_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata,
  input logic         out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[1:0] == 2'd3)))
    else $error("tlast does not match row");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken during read out");
endmodule

bind matrix4_transform_unit_core m4tu_checker u_m4tu_checker (.*);
